// File: sv/ddt_pkg.sv
// ============================================================================
// Directory table package
// Shared widths, codes, state encoding and the command and status bundles
// that join the controller and the datapath.
// ============================================================================
package ddt_pkg;

    localparam int DEF_MAX_ENTRIES = 32;
    localparam int DEF_KEY_BITS    = 256;

    localparam int KEY_FULL_W = 256;
    localparam int KEY_WORD_W = 64;
    localparam int HOST_W     = 32;
    localparam int PORT_W     = 16;
    localparam int CAPS_W     = 16;
    localparam int REC_W      = HOST_W + PORT_W + CAPS_W;
    localparam int INDEX_W    = 5;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 6;

    localparam int S_TDATA_W = 328;
    localparam int M_TDATA_W = 328;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_DUP   = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RD_ADDR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic rd_issue;
        logic finish;
    } ddt_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } ddt_stat_t;

endpackage

// File: sv/dedup_directory_table_top.sv
// ============================================================================
// Deduplicating directory table
// Stores node records keyed by public key and serves insert and read requests.
// ============================================================================
// The slave channel carries one request per handshake. s_tuser selects an
// insert (0) or a read of the entry at entry_index (1). The master channel
// returns exactly one result per request: status, entry count after the
// request, and for a successful read the stored key, host, port and caps.
// An insert scans the key memory through its single read port, one stored
// entry per cycle, and a matching key ends the scan early; a read fetches
// the indexed entry instead when it lies below the count. The result is
// then loaded into the output register. One request is in flight at a time,
// and the controller returns to idle, ready for the next request, at the
// edge that loads the result.
// The result sits in an output register, so the next request is accepted
// while the previous result waits; if the receiver still stalls when the
// next result is ready, the block holds it internally until the register
// frees. Reset empties the table and drops any pending result; the memories
// need no clearing because only entries below the count are ever read.
// ============================================================================
module dedup_directory_table_top
    import ddt_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int KEY_BITS    = DEF_KEY_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // key_word0, key_word1, key_word2, key_word3, host_addr, port_num,
    // cap_bits, entry_index, zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status, stored_count, out_key0, out_key1, out_key2, out_key3,
    // out_host, out_port, out_caps
    output logic [M_TDATA_W-1:0] m_tdata
);

    ddt_cmd_t  cmd;
    ddt_stat_t stat;

    ddt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    ddt_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: sv/ddt_ctrl.sv
// ============================================================================
// Directory table controller
// Sequences one request at a time through key scan, entry read and result.
// ============================================================================
module ddt_ctrl
    import ddt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  logic      s_tuser,
    output logic      s_tready,
    output ddt_cmd_t  cmd,
    input  ddt_stat_t stat
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = (s_tuser == REQ_READ) ? ST_RD_ADDR : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_RD_ADDR: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/ddt_datapath.sv
// ============================================================================
// Directory table datapath
// Request registers, key and record memories, scan compare and result register.
// ============================================================================
module ddt_datapath
    import ddt_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int KEY_BITS    = DEF_KEY_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  ddt_cmd_t             cmd,
    output ddt_stat_t            stat,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    logic [KEY_BITS-1:0] key_mem [MAX_ENTRIES];
    logic [REC_W-1:0]    rec_mem [MAX_ENTRIES];
    logic [KEY_BITS-1:0] key_rd_reg;
    logic [REC_W-1:0]    rec_rd_reg;

    logic                 req_read_reg, req_read_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [REC_W-1:0]     rec_reg, rec_next;
    logic [INDEX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    logic                 pend_reg, pend_next;
    logic                 dup_reg, dup_next;
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [KEY_FULL_W-1:0] key_in;
    logic [KEY_FULL_W-1:0] key_out;
    logic                  scan_issue;
    logic                  match;
    logic                  full;
    logic                  idx_ok;
    logic                  mem_we;
    logic                  mem_re;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      wr_addr;
    status_t               status;
    logic [CNT_W-1:0]      count_after;

    assign key_in = {s_tdata[63:0], s_tdata[127:64], s_tdata[191:128], s_tdata[255:192]};

    assign scan_issue = cmd.scan && (ptr_reg < count_reg);
    assign match      = pend_reg && (key_rd_reg == key_reg);
    assign full       = count_reg >= CNT_W'(MAX_ENTRIES);
    assign idx_ok     = CMP_W'(idx_reg) < CMP_W'(count_reg);
    assign mem_we     = cmd.finish && (req_read_reg == REQ_INSERT) && !dup_reg && !full;
    assign mem_re     = scan_issue || (cmd.rd_issue && idx_ok);
    assign rd_addr    = cmd.rd_issue ? IDX_W'(idx_reg) : ptr_reg[IDX_W-1:0];
    assign wr_addr    = count_reg[IDX_W-1:0];
    assign key_out    = KEY_FULL_W'(key_rd_reg);

    assign stat.scan_done = dup_reg || (!(ptr_reg < count_reg) && !pend_reg);
    assign stat.out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[wr_addr] <= key_reg;
            rec_mem[wr_addr] <= rec_reg;
        end
        if (mem_re) begin
            key_rd_reg <= key_mem[rd_addr];
            rec_rd_reg <= rec_mem[rd_addr];
        end
    end

    always_comb begin
        req_read_next  = req_read_reg;
        key_next       = key_reg;
        rec_next       = rec_reg;
        idx_next       = idx_reg;
        ptr_next       = ptr_reg;
        pend_next      = 1'b0;
        dup_next       = dup_reg;
        count_next     = count_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        status         = STAT_OK;
        count_after    = count_reg;

        if (cmd.load) begin
            req_read_next = s_tuser;
            key_next      = key_in[KEY_BITS-1:0];
            rec_next      = {s_tdata[287:256], s_tdata[303:288], s_tdata[319:304]};
            idx_next      = s_tdata[324:320];
            ptr_next      = '0;
            dup_next      = 1'b0;
        end

        if (scan_issue) begin
            ptr_next  = ptr_reg + 1'b1;
            pend_next = 1'b1;
        end
        if (match) begin
            dup_next = 1'b1;
        end

        if (req_read_reg == REQ_READ) begin
            status = idx_ok ? STAT_OK : STAT_RANGE;
        end else if (dup_reg) begin
            status = STAT_DUP;
        end else if (full) begin
            status = STAT_FULL;
        end
        if (mem_we) begin
            count_after = count_reg + 1'b1;
        end

        if (cmd.finish) begin
            count_next     = count_after;
            out_valid_next = 1'b1;
            out_data_next  = '0;
            out_data_next[1:0] = status;
            out_data_next[7:2] = COUNT_W'(count_after);
            if ((req_read_reg == REQ_READ) && idx_ok) begin
                out_data_next[71:8]    = key_out[255:192];
                out_data_next[135:72]  = key_out[191:128];
                out_data_next[199:136] = key_out[127:64];
                out_data_next[263:200] = key_out[63:0];
                out_data_next[295:264] = rec_rd_reg[63:32];
                out_data_next[311:296] = rec_rd_reg[31:16];
                out_data_next[327:312] = rec_rd_reg[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            dup_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            dup_reg       <= dup_next;
            out_valid_reg <= out_valid_next;
        end
        req_read_reg <= req_read_next;
        key_reg      <= key_next;
        rec_reg      <= rec_next;
        idx_reg      <= idx_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: sv/ddt_checker.sv
// ============================================================================
// Directory table port checker
// Watches the top-level ports for reset, busy and result payload behavior.
// ============================================================================
module ddt_checker
    import ddt_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    a_no_payload_on_failure: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] == STAT_DUP || m_tdata[1:0] == STAT_FULL
                      || m_tdata[1:0] == STAT_RANGE)) |-> (m_tdata[327:8] == '0))
        else $error("entry fields nonzero on a result without entry data");

endmodule

bind dedup_directory_table_top ddt_checker u_ddt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
